// File: sv/xenc_pkg.sv
// ============================================================================
// xenc_pkg: shared types and constants for the x86-64 instruction encoder
// Holds the command codes, the opcode bytes and the decoded-item record that
// the decoder passes to the byte emitter.
// ============================================================================
`default_nettype none

package xenc_pkg;

  // Largest instruction in the supported subset (mov r64, imm64)
  localparam int MaxBytes = 10;

  // Command codes
  localparam logic [3:0] CMD_RESTART = 4'd0;
  localparam logic [3:0] CMD_MOV_RR  = 4'd1;
  localparam logic [3:0] CMD_MOV_RI  = 4'd2;
  localparam logic [3:0] CMD_LEA_RIP = 4'd3;
  localparam logic [3:0] CMD_PUSH    = 4'd4;
  localparam logic [3:0] CMD_POP     = 4'd5;
  localparam logic [3:0] CMD_XOR_RR  = 4'd6;
  localparam logic [3:0] CMD_XOR_R0  = 4'd7;
  localparam logic [3:0] CMD_ADD     = 4'd8;
  localparam logic [3:0] CMD_SUB     = 4'd9;
  localparam logic [3:0] CMD_SYSCALL = 4'd10;
  localparam logic [3:0] CMD_RET     = 4'd11;
  localparam logic [3:0] CMD_NOP     = 4'd12;
  localparam logic [3:0] CMD_JMP     = 4'd13;
  localparam logic [3:0] CMD_BYTE    = 4'd14;

  // Opcode and prefix bytes
  localparam logic [7:0] REX_BASE    = 8'h40;
  localparam logic [7:0] REX_W_BIT   = 8'h08;
  localparam logic [7:0] OP_MOV_IMM  = 8'hB8;
  localparam logic [7:0] OP_MOV_RR   = 8'h89;
  localparam logic [7:0] OP_XOR_RR   = 8'h31;
  localparam logic [7:0] OP_GRP1     = 8'h81;
  localparam logic [7:0] OP_LEA      = 8'h8D;
  localparam logic [7:0] OP_JMP      = 8'hE9;
  localparam logic [7:0] OP_PUSH     = 8'h50;
  localparam logic [7:0] OP_POP      = 8'h58;
  localparam logic [7:0] REX_B_ONLY  = 8'h41;
  localparam logic [7:0] OP_RET      = 8'hC3;
  localparam logic [7:0] OP_NOP      = 8'h90;
  localparam logic [7:0] OP_ESC      = 8'h0F;
  localparam logic [7:0] OP_SYSCALL  = 8'h05;
  localparam logic [7:0] MODRM_REG   = 8'hC0;
  localparam logic [7:0] MODRM_RIP   = 8'h05;

  // Group-1 opcode extensions
  localparam logic [2:0] EXT_ADD = 3'd0;
  localparam logic [2:0] EXT_SUB = 3'd5;
  localparam logic [2:0] EXT_XOR = 3'd6;

  // One decoded instruction, ready for the byte emitter
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;       // bytes[0] leaves first
    logic [3:0]               nres;        // results to deliver, 1..10
    logic                     tail_void;   // final result carries no byte
    logic                     tail_status; // status of a void final result
  } item_t;

endpackage

`default_nettype wire

// File: sv/xenc_decode.sv
// ============================================================================
// xenc_decode: instruction to byte-string decoder
// Builds the machine bytes of one instruction, works out rel32 displacements
// and clips the byte count against the remaining text capacity.
// ============================================================================
`default_nettype none

module xenc_decode #(
  parameter int TEXT_CAPACITY = 65536,
  parameter int OffW          = $clog2(TEXT_CAPACITY + 1)
) (
  input  wire logic [3:0]      command_i,
  input  wire logic [3:0]      dst_reg_i,
  input  wire logic [3:0]      src_reg_i,
  input  wire logic [63:0]     operand_value_i,
  input  wire logic [63:0]     load_base_i,
  input  wire logic [OffW-1:0] start_i,
  output xenc_pkg::item_t      item_o,
  output logic [OffW-1:0]      next_offset_o
);

  localparam logic [OffW:0] Cap = (OffW+1)'(TEXT_CAPACITY);

  logic [xenc_pkg::MaxBytes-1:0][7:0] bytes;
  logic [3:0]  n;
  logic [2:0]  d3;
  logic [2:0]  s3;
  logic [2:0]  ext;
  logic [31:0] pc_lo;
  logic [31:0] rel_lea;
  logic [31:0] rel_jmp;
  logic [31:0] imm32;
  logic [7:0]  rex_rm;
  logic [7:0]  rex_rr;
  logic [7:0]  rex_reg;
  logic [7:0]  stack_op;
  logic [OffW:0] end_off;
  logic [OffW:0] room;
  logic        ovf;

  assign d3 = dst_reg_i[2:0];
  assign s3 = src_reg_i[2:0];

  // REX.W with REX.R from the ModRM reg register, REX.B from the rm register
  assign rex_rm  = xenc_pkg::REX_BASE | xenc_pkg::REX_W_BIT | {7'd0, dst_reg_i[3]};
  assign rex_rr  = rex_rm | {5'd0, src_reg_i[3], 2'd0};
  assign rex_reg = xenc_pkg::REX_BASE | xenc_pkg::REX_W_BIT | {5'd0, dst_reg_i[3], 2'd0};

  // Displacements only need the low 32 bits of the address arithmetic
  assign pc_lo   = load_base_i[31:0] + 32'(start_i);
  assign rel_lea = operand_value_i[31:0] - pc_lo - 32'd7;
  assign rel_jmp = operand_value_i[31:0] - pc_lo - 32'd5;

  assign stack_op = (command_i == xenc_pkg::CMD_PUSH) ? xenc_pkg::OP_PUSH
                                                       : xenc_pkg::OP_POP;

  // Group-1 extension and immediate
  always_comb begin
    case (command_i)
      xenc_pkg::CMD_ADD: begin
        ext   = xenc_pkg::EXT_ADD;
        imm32 = operand_value_i[31:0];
      end
      xenc_pkg::CMD_SUB: begin
        ext   = xenc_pkg::EXT_SUB;
        imm32 = operand_value_i[31:0];
      end
      default: begin
        ext   = xenc_pkg::EXT_XOR;
        imm32 = 32'd0;
      end
    endcase
  end

  // Byte string per command
  always_comb begin
    bytes = '0;
    n     = 4'd0;
    case (command_i)
      xenc_pkg::CMD_MOV_RR, xenc_pkg::CMD_XOR_RR: begin
        bytes[0] = rex_rr;
        bytes[1] = (command_i == xenc_pkg::CMD_MOV_RR) ? xenc_pkg::OP_MOV_RR
                                                        : xenc_pkg::OP_XOR_RR;
        bytes[2] = xenc_pkg::MODRM_REG | {2'd0, s3, d3};
        n        = 4'd3;
      end
      xenc_pkg::CMD_MOV_RI: begin
        bytes[0] = rex_rm;
        bytes[1] = xenc_pkg::OP_MOV_IMM | {5'd0, d3};
        for (int i = 0; i < 8; i++) begin
          bytes[2+i] = operand_value_i[8*i +: 8];
        end
        n        = 4'd10;
      end
      xenc_pkg::CMD_LEA_RIP: begin
        bytes[0] = rex_reg;
        bytes[1] = xenc_pkg::OP_LEA;
        bytes[2] = xenc_pkg::MODRM_RIP | {2'd0, d3, 3'd0};
        for (int i = 0; i < 4; i++) begin
          bytes[3+i] = rel_lea[8*i +: 8];
        end
        n        = 4'd7;
      end
      xenc_pkg::CMD_PUSH, xenc_pkg::CMD_POP: begin
        if (dst_reg_i[3]) begin
          bytes[0] = xenc_pkg::REX_B_ONLY;
          bytes[1] = stack_op | {5'd0, d3};
          n        = 4'd2;
        end else begin
          bytes[0] = stack_op | {5'd0, d3};
          n        = 4'd1;
        end
      end
      xenc_pkg::CMD_XOR_R0, xenc_pkg::CMD_ADD, xenc_pkg::CMD_SUB: begin
        bytes[0] = rex_rm;
        bytes[1] = xenc_pkg::OP_GRP1;
        bytes[2] = xenc_pkg::MODRM_REG | {2'd0, ext, d3};
        for (int i = 0; i < 4; i++) begin
          bytes[3+i] = imm32[8*i +: 8];
        end
        n        = 4'd7;
      end
      xenc_pkg::CMD_SYSCALL: begin
        bytes[0] = xenc_pkg::OP_ESC;
        bytes[1] = xenc_pkg::OP_SYSCALL;
        n        = 4'd2;
      end
      xenc_pkg::CMD_RET: begin
        bytes[0] = xenc_pkg::OP_RET;
        n        = 4'd1;
      end
      xenc_pkg::CMD_NOP: begin
        bytes[0] = xenc_pkg::OP_NOP;
        n        = 4'd1;
      end
      xenc_pkg::CMD_JMP: begin
        bytes[0] = xenc_pkg::OP_JMP;
        for (int i = 0; i < 4; i++) begin
          bytes[1+i] = rel_jmp[8*i +: 8];
        end
        n        = 4'd5;
      end
      xenc_pkg::CMD_BYTE: begin
        bytes[0] = operand_value_i[7:0];
        n        = 4'd1;
      end
      default: begin
        bytes = '0;
        n     = 4'd0;
      end
    endcase
  end

  // Capacity clip: bytes that fit go out, the first that does not becomes
  // an overflow marker
  assign end_off = {1'b0, start_i} + (OffW+1)'(n);
  assign room    = Cap - {1'b0, start_i};
  assign ovf     = (n != 4'd0) && (end_off > Cap);

  always_comb begin
    item_o.bytes       = bytes;
    item_o.tail_void   = ovf || (n == 4'd0);
    item_o.tail_status = ovf;
    if (ovf) begin
      item_o.nres = 4'(room) + 4'd1;
    end else if (n == 4'd0) begin
      item_o.nres = 4'd1;
    end else begin
      item_o.nres = n;
    end
  end

  // Running offset after this instruction
  always_comb begin
    if (command_i == xenc_pkg::CMD_RESTART) begin
      next_offset_o = '0;
    end else if (ovf) begin
      next_offset_o = OffW'(Cap);
    end else begin
      next_offset_o = OffW'(end_off);
    end
  end

endmodule

`default_nettype wire

// File: sv/xenc_emit.sv
// ============================================================================
// xenc_emit: byte emitter with output register
// Holds one decoded instruction in a shift buffer, sends one result per cycle
// unless m_axis_tready stalls; loads the next item as the last result leaves.
// ============================================================================
`default_nettype none

module xenc_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  input  wire xenc_pkg::item_t item_i,
  output logic                 take_o,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // [7:0] out_byte
  output logic                 m_axis_tlast,
  output logic [1:0]           m_axis_tuser   // [0] byte_valid, [1] status
);

  logic [xenc_pkg::MaxBytes-1:0][7:0] bytes_q;
  logic       tail_void_q;
  logic       tail_status_q;
  logic [3:0] rem_q;
  logic       buf_vld_q;
  logic       out_vld_q;
  logic [7:0] out_byte_q;
  logic       out_bv_q;
  logic       out_last_q;
  logic       out_st_q;
  logic       adv;
  logic       issue;
  logic       load;
  logic       at_last;

  // Handshake between buffer and output register
  assign adv     = !out_vld_q || m_axis_tready;
  assign issue   = adv && buf_vld_q;
  assign at_last = (rem_q == 4'd1);
  assign take_o  = !buf_vld_q || (issue && at_last);
  assign load    = item_valid_i && take_o;

  // Buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_vld_q <= 1'b0;
      rem_q     <= 4'd0;
    end else if (load) begin
      buf_vld_q <= 1'b1;
      rem_q     <= item_i.nres;
    end else if (issue) begin
      buf_vld_q <= !at_last;
      rem_q     <= rem_q - 4'd1;
    end
  end

  // Buffer payload: shift toward byte 0 as results leave
  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q       <= item_i.bytes;
      tail_void_q   <= item_i.tail_void;
      tail_status_q <= item_i.tail_status;
    end else if (issue) begin
      bytes_q <= {8'd0, bytes_q[xenc_pkg::MaxBytes-1:1]};
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= buf_vld_q;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_last_q <= at_last;
      if (at_last && tail_void_q) begin
        out_byte_q <= 8'd0;
        out_bv_q   <= 1'b0;
        out_st_q   <= tail_status_q;
      end else begin
        out_byte_q <= bytes_q[0];
        out_bv_q   <= 1'b1;
        out_st_q   <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_st_q, out_bv_q};

endmodule

`default_nettype wire

// File: sv/x86_64_instruction_byte_encoder_unit.sv
// ============================================================================
// x86_64_instruction_byte_encoder_unit: x86-64 instruction encoder (subset)
// Turns pre-parsed instructions into machine bytes, one byte per transfer,
// tracking the text offset against a fixed capacity.
// ============================================================================
// Each accepted instruction yields one output transfer per machine byte, one
// to ten transfers, at one transfer per cycle while m_axis_tready stays high;
// the next instruction enters while the last byte of the current one leaves.
// The first output byte passes through the input register, the byte buffer
// and the output register. Restart and unused codes give a single transfer
// with byte_valid low. Once the text offset reaches TEXT_CAPACITY, the byte
// that does not fit is replaced by a final transfer with byte_valid low and
// status high, until a restart or reset. load_base lies at APB byte address
// 0 and may only be written while no instruction is in flight.
`default_nettype none

module x86_64_instruction_byte_encoder_unit #(
  parameter int TEXT_CAPACITY = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Instruction input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] command, [7:4] dst_reg, [11:8] src_reg, [75:12] operand_value,
  // [79:76] zero
  input  wire logic [79:0] s_axis_tdata,
  // Byte output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser,   // [0] byte_valid, [1] status
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int OffW = $clog2(TEXT_CAPACITY + 1);

  logic [63:0]     load_base_q;
  logic [OffW-1:0] offset_q;
  logic [OffW-1:0] offset_d;
  logic            in_vld_q;
  logic [3:0]      cmd_q;
  logic [3:0]      dst_q;
  logic [3:0]      src_q;
  logic [63:0]     val_q;
  logic            take;
  logic            load;
  logic            cfg_wr;
  logic            sel_base;
  xenc_pkg::item_t item;

  // Configuration register
  assign pready   = 1'b1;
  assign sel_base = (paddr[3] == 1'b0);
  assign cfg_wr   = psel && penable && pwrite && sel_base;
  assign prdata   = sel_base ? load_base_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_base_q <= 64'h0000_0000_0040_0000;
    end else if (cfg_wr) begin
      load_base_q <= pwdata;
    end
  end

  // Input register
  assign load          = in_vld_q && take;
  assign s_axis_tready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tdata[3:0];
      dst_q <= s_axis_tdata[7:4];
      src_q <= s_axis_tdata[11:8];
      val_q <= s_axis_tdata[75:12];
    end
  end

  // Decode against the offset left by all earlier instructions
  xenc_decode #(
    .TEXT_CAPACITY (TEXT_CAPACITY),
    .OffW          (OffW)
  ) u_decode (
    .command_i       (cmd_q),
    .dst_reg_i       (dst_q),
    .src_reg_i       (src_q),
    .operand_value_i (val_q),
    .load_base_i     (load_base_q),
    .start_i         (offset_q),
    .item_o          (item),
    .next_offset_o   (offset_d)
  );

  // Running text offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (load) begin
      offset_q <= offset_d;
    end
  end

  // Byte emitter
  xenc_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (in_vld_q),
    .item_i        (item),
    .take_o        (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
